/* hw/rtl/vpe_pkg.sv */
// ----------------------------------------------------------------------------
// vpe_pkg
// Shared types, constants and helpers of the Verlet particle engine.
// ----------------------------------------------------------------------------
package vpe_pkg;

	localparam int NUM_PARTICLES = 1024;
	localparam int FRAC_BITS     = 16;
	localparam int PART_AW       = $clog2(NUM_PARTICLES);

	localparam int WORD_W = 32;
	localparam int RAD_W  = 31;
	localparam int BOX_W  = 31;
	localparam int IDX_W  = 10;

	// front queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	// shared root and divide unit, one result bit per step
	localparam int ITER_STEPS = 32;
	localparam int ITER_CW    = $clog2(ITER_STEPS);

	// configuration
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] REG_TIME_STEP  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_BOX_WIDTH  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_BOX_HEIGHT = 2'd2;

	localparam logic [WORD_W-1:0] TIME_STEP_RST  = 32'd1092;
	localparam logic [BOX_W-1:0]  BOX_WIDTH_RST  = 31'd52428800;
	localparam logic [BOX_W-1:0]  BOX_HEIGHT_RST = 31'd39321600;

	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_INTEG   = 2'd1,
		REQ_COLLIDE = 2'd2
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] time_step;
		logic [BOX_W-1:0]  box_width;
		logic [BOX_W-1:0]  box_height;
	} cfg_t;

	// one classified item in the front queue
	typedef struct packed {
		req_t                     kind;
		logic [IDX_W-1:0]         a;
		logic [IDX_W-1:0]         b;
		logic signed [WORD_W-1:0] v0x;
		logic signed [WORD_W-1:0] v0y;
		logic signed [WORD_W-1:0] v1x;
		logic signed [WORD_W-1:0] v1y;
		logic [RAD_W-1:0]         rad;
	} entry_t;

	typedef enum logic {
		AOP_SQRT = 1'b0,
		AOP_DIV  = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic        start;
		arith_op_t   op;
		logic [63:0] arg;
		logic [32:0] dsr;
	} arith_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} arith_rsp_t;

	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > S32_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/vpe_if.sv */
// ----------------------------------------------------------------------------
// vpe_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface vpe_cmd_if;
	import vpe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic [IDX_W-1:0]         particle;
	logic [IDX_W-1:0]         partner;
	logic signed [WORD_W-1:0] load_x;
	logic signed [WORD_W-1:0] load_y;
	logic signed [WORD_W-1:0] speed_x;
	logic signed [WORD_W-1:0] speed_y;
	logic [RAD_W-1:0]         size;
	logic signed [WORD_W-1:0] push_x;
	logic signed [WORD_W-1:0] push_y;

	modport source (output valid, req_type, particle, partner, load_x, load_y,
		speed_x, speed_y, size, push_x, push_y, input ready);
	modport sink (input valid, req_type, particle, partner, load_x, load_y,
		speed_x, speed_y, size, push_x, push_y, output ready);
endinterface

interface vpe_res_if;
	import vpe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         which;
	logic signed [WORD_W-1:0] out_x;
	logic signed [WORD_W-1:0] out_y;
	logic                     overlapped;
	logic                     last;

	modport source (output valid, which, out_x, out_y, overlapped, last, input ready);
	modport sink (input valid, which, out_x, out_y, overlapped, last, output ready);
endinterface

/* hw/rtl/verlet_particle_engine.sv */
// ----------------------------------------------------------------------------
// verlet_particle_engine
// Circle particle table with load, Verlet integrate and pairwise collide.
// ----------------------------------------------------------------------------
// latency to a result handshake depends on the item kind and stalls while the
// result register is still held; a collide uses the shared unit for a square root
// and, on overlap, two divisions; items run one at a time in the back end, and
// a 4-item queue buffers input
// reset clears control state and restores the register defaults; the particle
// store is not cleared and an entry holds no defined value until loaded
module verlet_particle_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [vpe_pkg::CFG_IW-1:0] wr_index,
	input  logic [vpe_pkg::WORD_W-1:0] wr_data,
	vpe_cmd_if.sink                    cmd,
	vpe_res_if.source                  res
);
	import vpe_pkg::*;

	cfg_t       cfg_q;
	logic       pop;
	logic       avail;
	entry_t     head;
	arith_req_t areq;
	arith_rsp_t arsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step  <= TIME_STEP_RST;
			cfg_q.box_width  <= BOX_WIDTH_RST;
			cfg_q.box_height <= BOX_HEIGHT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TIME_STEP:  cfg_q.time_step  <= wr_data;
				REG_BOX_WIDTH:  cfg_q.box_width  <= wr_data[BOX_W-1:0];
				REG_BOX_HEIGHT: cfg_q.box_height <= wr_data[BOX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	vpe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pop    (pop),
		.avail  (avail),
		.head   (head)
	);

	vpe_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	vpe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.avail  (avail),
		.head   (head),
		.pop    (pop),
		.areq   (areq),
		.arsp   (arsp),
		.res    (res)
	);

endmodule

/* hw/rtl/vpe_front.sv */
// ----------------------------------------------------------------------------
// vpe_front
// Accepts command items, drops unknown or out-of-range ones, prepares the
// load fields and queues the rest for the back end.
// ----------------------------------------------------------------------------
module vpe_front (
	input  logic            clk,
	input  logic            arst_n,
	vpe_cmd_if.sink         cmd,
	input  logic            pop,
	output logic            avail,
	output vpe_pkg::entry_t head
);
	import vpe_pkg::*;

	entry_t           fifo_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	entry_t           e;
	logic             keep;
	logic             in_a;
	logic             in_b;
	logic             push;

	assign cmd.ready = (count_q != QCW'(QDEPTH));
	assign avail     = (count_q != '0);
	assign head      = fifo_q[rd_ptr_q];

	always_comb begin
		in_a = (32'(cmd.particle) < NUM_PARTICLES);
		in_b = (32'(cmd.partner) < NUM_PARTICLES);
		case (cmd.req_type)
			REQ_LOAD, REQ_INTEG: begin
				keep = in_a;
			end
			REQ_COLLIDE: begin
				keep = in_a && in_b;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		e.kind = req_t'(cmd.req_type);
		e.a    = cmd.particle;
		e.b    = cmd.partner;
		e.v0x  = (cmd.req_type == REQ_LOAD) ? cmd.load_x : cmd.push_x;
		e.v0y  = (cmd.req_type == REQ_LOAD) ? cmd.load_y : cmd.push_y;
		// previous position of a loaded particle
		e.v1x  = sat32(66'(cmd.load_x) - 66'(cmd.speed_x));
		e.v1y  = sat32(66'(cmd.load_y) - 66'(cmd.speed_y));
		e.rad  = cmd.size;
	end

	assign push = cmd.valid && cmd.ready && keep;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + QCW'(1))
		else $error("queue count lost a pushed item");

endmodule

/* hw/rtl/vpe_arith.sv */
// ----------------------------------------------------------------------------
// vpe_arith
// Shared iterative unit: floor square root of a 64-bit value or 64 by 33 bit
// division, one result bit per cycle.
// ----------------------------------------------------------------------------
module vpe_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  vpe_pkg::arith_req_t req,
	output vpe_pkg::arith_rsp_t rsp
);
	import vpe_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [ITER_CW-1:0] cnt_q;
	arith_op_t          op_q;
	logic [34:0]        rem_q;
	logic [63:0]        sh_q;
	logic [32:0]        dsr_q;
	logic [31:0]        res_q;
	logic [34:0]        rp;
	logic [34:0]        trial;
	logic               ge;

	always_comb begin
		if (op_q == AOP_SQRT) begin
			rp    = {rem_q[32:0], sh_q[63:62]};
			trial = {1'b0, res_q, 2'b01};
		end else begin
			rp    = {rem_q[33:0], sh_q[63]};
			trial = {2'b00, dsr_q};
		end
		ge = (rp >= trial);
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			dsr_q <= req.dsr;
			res_q <= '0;
			if (req.op == AOP_SQRT) begin
				rem_q <= '0;
				sh_q  <= req.arg;
			end else begin
				rem_q <= {3'b000, req.arg[63:32]};
				sh_q  <= {req.arg[31:0], 32'd0};
			end
		end else if (busy_q) begin
			rem_q <= ge ? (rp - trial) : rp;
			res_q <= {res_q[30:0], ge};
			sh_q  <= (op_q == AOP_SQRT) ? (sh_q << 2) : (sh_q << 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_CW'(ITER_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("iterative unit started while busy");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 |=> done_q && !busy_q)
		else $error("iterative unit did not finish on its last step");

endmodule

/* hw/rtl/vpe_back.sv */
// ----------------------------------------------------------------------------
// vpe_back
// Carries out queued items against the particle store: load, Verlet step
// with wall clamp, and pairwise collision, and holds the result register.
// ----------------------------------------------------------------------------
module vpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  vpe_pkg::cfg_t       cfg,
	input  logic                avail,
	input  vpe_pkg::entry_t     head,
	output logic                pop,
	output vpe_pkg::arith_req_t areq,
	input  vpe_pkg::arith_rsp_t arsp,
	vpe_res_if.source           res
);
	import vpe_pkg::*;

	typedef enum logic [23:0] {
		ST_IDLE   = 24'h000001,
		ST_LD     = 24'h000002,
		ST_I_GET  = 24'h000004,
		ST_I_M1   = 24'h000008,
		ST_I_T    = 24'h000010,
		ST_I_M2   = 24'h000020,
		ST_I_P    = 24'h000040,
		ST_I_W    = 24'h000080,
		ST_I_WR   = 24'h000100,
		ST_C_RDB  = 24'h000200,
		ST_C_GETB = 24'h000400,
		ST_C_SQ1  = 24'h000800,
		ST_C_SQ2  = 24'h001000,
		ST_C_SUM  = 24'h002000,
		ST_C_ROOT = 24'h004000,
		ST_C_CMP  = 24'h008000,
		ST_C_MX   = 24'h010000,
		ST_C_DVX  = 24'h020000,
		ST_C_WX   = 24'h040000,
		ST_C_DVY  = 24'h080000,
		ST_C_WY   = 24'h100000,
		ST_C_UPD  = 24'h200000,
		ST_C_EA   = 24'h400000,
		ST_C_EB   = 24'h800000
	} state_t;

	// particle store
	logic signed [WORD_W-1:0] now_x_mem [NUM_PARTICLES];
	logic signed [WORD_W-1:0] now_y_mem [NUM_PARTICLES];
	logic signed [WORD_W-1:0] bef_x_mem [NUM_PARTICLES];
	logic signed [WORD_W-1:0] bef_y_mem [NUM_PARTICLES];
	logic [RAD_W-1:0]         rad_mem   [NUM_PARTICLES];

	logic signed [WORD_W-1:0] now_x_rd_q, now_y_rd_q, bef_x_rd_q, bef_y_rd_q;
	logic [RAD_W-1:0]         rad_rd_q;

	logic [PART_AW-1:0]       rd_addr, wr_addr;
	logic                     we_pos, we_bef, we_rad;
	logic signed [WORD_W-1:0] wd_x, wd_y, wd_bx, wd_by;

	state_t                   state_q, state_d;
	entry_t                   op_q;
	logic                     axis_q;
	logic signed [WORD_W-1:0] ax_q, ay_q, bx_q, by_q, bef_x_q, bef_y_q;
	logic [RAD_W-1:0]         ra_q;
	logic signed [65:0]       prod_q;
	logic signed [WORD_W-1:0] t_q, p_q;
	logic signed [32:0]       diff_q;
	logic signed [33:0]       dx_q, dy_q;
	logic [WORD_W-1:0]        msum_q, dist_q, ovl_q, qx_q, qy_q;
	logic [63:0]              sq_q;
	logic                     ov_q;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_which_q;
	logic signed [WORD_W-1:0] out_x_q, out_y_q;
	logic                     out_ov_q, out_last_q;
	logic                     out_free, out_load;
	logic [IDX_W-1:0]         ld_which;
	logic signed [WORD_W-1:0] ld_x, ld_y;
	logic                     ld_ov, ld_last;

	logic                     mul_en;
	logic signed [32:0]       mul_a, mul_b;

	logic signed [WORD_W-1:0] cur, bef, acc;
	logic [BOX_W-1:0]         wall;
	logic signed [65:0]       u;
	logic signed [33:0]       s_twor, s_wall;
	logic                     hit_lo, hit_hi;
	logic signed [WORD_W-1:0] lim, w_now, w_bef;
	logic [33:0]              mx, my;
	logic                     far;
	logic [64:0]              sum65;
	logic signed [32:0]       cx, cy;

	assign out_free = !out_valid_q || res.ready;

	// integrate datapath for the axis in work
	always_comb begin
		cur    = axis_q ? ay_q : ax_q;
		bef    = axis_q ? bef_y_q : bef_x_q;
		acc    = axis_q ? op_q.v0y : op_q.v0x;
		wall   = axis_q ? cfg.box_height : cfg.box_width;
		u      = prod_q >>> FRAC_BITS;
		s_twor = $signed({2'b00, ra_q, 1'b0});
		s_wall = $signed({3'b000, wall});
		hit_lo = p_q[31];
		hit_hi = (34'(p_q) + s_twor) > s_wall;
		lim    = sat32(66'(s_wall - s_twor));
		if (hit_hi) begin
			w_now = lim;
			w_bef = hit_lo ? '0 : p_q;
		end else if (hit_lo) begin
			w_now = '0;
			w_bef = p_q;
		end else begin
			w_now = p_q;
			w_bef = cur;
		end
	end

	// collide datapath
	always_comb begin
		mx    = dx_q[33] ? 34'(-dx_q) : 34'(dx_q);
		my    = dy_q[33] ? 34'(-dy_q) : 34'(dy_q);
		far   = (mx[33:32] != 2'b00) || (my[33:32] != 2'b00);
		sum65 = {1'b0, sq_q} + {1'b0, prod_q[63:0]};
		cx    = dx_q[33] ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
		cy    = dy_q[33] ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		rd_addr    = (state_q == ST_IDLE) ? PART_AW'(head.a) : PART_AW'(op_q.b);
		wr_addr    = PART_AW'(op_q.a);
		we_pos     = 1'b0;
		we_bef     = 1'b0;
		we_rad     = 1'b0;
		wd_x       = ax_q;
		wd_y       = ay_q;
		wd_bx      = bef_x_q;
		wd_by      = bef_y_q;
		mul_en     = 1'b0;
		mul_a      = 33'(acc);
		mul_b      = $signed({1'b0, cfg.time_step});
		areq.start = 1'b0;
		areq.op    = AOP_SQRT;
		areq.arg   = sum65[63:0];
		areq.dsr   = {dist_q, 1'b0};
		out_load   = 1'b0;
		ld_which   = op_q.a;
		ld_x       = ax_q;
		ld_y       = ay_q;
		ld_ov      = 1'b0;
		ld_last    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					case (head.kind)
						REQ_LOAD:    state_d = ST_LD;
						REQ_INTEG:   state_d = ST_I_GET;
						REQ_COLLIDE: state_d = ST_C_RDB;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_LD: begin
				if (out_free) begin
					we_pos   = 1'b1;
					we_bef   = 1'b1;
					we_rad   = 1'b1;
					wd_x     = op_q.v0x;
					wd_y     = op_q.v0y;
					wd_bx    = op_q.v1x;
					wd_by    = op_q.v1y;
					out_load = 1'b1;
					ld_x     = op_q.v0x;
					ld_y     = op_q.v0y;
					state_d  = ST_IDLE;
				end
			end
			ST_I_GET: state_d = ST_I_M1;
			ST_I_M1: begin
				mul_en  = 1'b1;
				state_d = ST_I_T;
			end
			ST_I_T: state_d = ST_I_M2;
			ST_I_M2: begin
				mul_en  = 1'b1;
				mul_a   = 33'(t_q);
				state_d = ST_I_P;
			end
			ST_I_P: state_d = ST_I_W;
			ST_I_W: state_d = axis_q ? ST_I_WR : ST_I_M1;
			ST_I_WR: begin
				if (out_free) begin
					we_pos   = 1'b1;
					we_bef   = 1'b1;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_C_RDB: state_d = ST_C_GETB;
			ST_C_GETB: state_d = ST_C_SQ1;
			ST_C_SQ1: begin
				if (far) begin
					state_d = ST_C_EA;
				end else begin
					mul_en  = 1'b1;
					mul_a   = $signed({1'b0, mx[31:0]});
					mul_b   = $signed({1'b0, mx[31:0]});
					state_d = ST_C_SQ2;
				end
			end
			ST_C_SQ2: begin
				mul_en  = 1'b1;
				mul_a   = $signed({1'b0, my[31:0]});
				mul_b   = $signed({1'b0, my[31:0]});
				state_d = ST_C_SUM;
			end
			ST_C_SUM: begin
				// squared length past 64 bits cannot overlap
				if (sum65[64]) begin
					state_d = ST_C_EA;
				end else begin
					areq.start = 1'b1;
					state_d    = ST_C_ROOT;
				end
			end
			ST_C_ROOT: begin
				if (arsp.done) begin
					state_d = ST_C_CMP;
				end
			end
			ST_C_CMP: begin
				if ((dist_q < msum_q) && (dist_q != '0)) begin
					state_d = ST_C_MX;
				end else begin
					state_d = ST_C_EA;
				end
			end
			ST_C_MX: begin
				mul_en  = 1'b1;
				mul_a   = $signed({1'b0, mx[31:0]});
				mul_b   = $signed({1'b0, ovl_q});
				state_d = ST_C_DVX;
			end
			ST_C_DVX: begin
				// divider takes the x product while y is multiplied
				areq.start = 1'b1;
				areq.op    = AOP_DIV;
				areq.arg   = prod_q[63:0];
				mul_en     = 1'b1;
				mul_a      = $signed({1'b0, my[31:0]});
				mul_b      = $signed({1'b0, ovl_q});
				state_d    = ST_C_WX;
			end
			ST_C_WX: begin
				if (arsp.done) begin
					state_d = ST_C_DVY;
				end
			end
			ST_C_DVY: begin
				areq.start = 1'b1;
				areq.op    = AOP_DIV;
				areq.arg   = prod_q[63:0];
				state_d    = ST_C_WY;
			end
			ST_C_WY: begin
				if (arsp.done) begin
					state_d = ST_C_UPD;
				end
			end
			ST_C_UPD: state_d = ST_C_EA;
			ST_C_EA: begin
				if (out_free) begin
					we_pos   = 1'b1;
					out_load = 1'b1;
					ld_ov    = ov_q;
					ld_last  = 1'b0;
					state_d  = ST_C_EB;
				end
			end
			ST_C_EB: begin
				if (out_free) begin
					we_pos   = 1'b1;
					wr_addr  = PART_AW'(op_q.b);
					wd_x     = bx_q;
					wd_y     = by_q;
					out_load = 1'b1;
					ld_which = op_q.b;
					ld_x     = bx_q;
					ld_y     = by_q;
					ld_ov    = ov_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// store ports
	always_ff @(posedge clk) begin
		if (we_pos) begin
			now_x_mem[wr_addr] <= wd_x;
			now_y_mem[wr_addr] <= wd_y;
		end
		if (we_bef) begin
			bef_x_mem[wr_addr] <= wd_bx;
			bef_y_mem[wr_addr] <= wd_by;
		end
		if (we_rad) begin
			rad_mem[wr_addr] <= op_q.rad;
		end
		now_x_rd_q <= now_x_mem[rd_addr];
		now_y_rd_q <= now_y_mem[rd_addr];
		bef_x_rd_q <= bef_x_mem[rd_addr];
		bef_y_rd_q <= bef_y_mem[rd_addr];
		rad_rd_q   <= rad_mem[rd_addr];
	end

	// working registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			ST_IDLE: begin
				op_q   <= head;
				axis_q <= 1'b0;
			end
			ST_I_GET: begin
				ax_q    <= now_x_rd_q;
				ay_q    <= now_y_rd_q;
				bef_x_q <= bef_x_rd_q;
				bef_y_q <= bef_y_rd_q;
				ra_q    <= rad_rd_q;
			end
			ST_I_T: begin
				t_q    <= sat32(prod_q >>> FRAC_BITS);
				diff_q <= 33'(cur) - 33'(bef);
			end
			ST_I_P: begin
				p_q <= sat32(66'(cur) + 66'(diff_q) + u);
			end
			ST_I_W: begin
				axis_q <= 1'b1;
				if (axis_q) begin
					ay_q    <= w_now;
					bef_y_q <= w_bef;
				end else begin
					ax_q    <= w_now;
					bef_x_q <= w_bef;
				end
			end
			ST_C_RDB: begin
				ax_q <= now_x_rd_q;
				ay_q <= now_y_rd_q;
				ra_q <= rad_rd_q;
				ov_q <= 1'b0;
			end
			ST_C_GETB: begin
				bx_q   <= now_x_rd_q;
				by_q   <= now_y_rd_q;
				// centre of partner minus centre of particle
				dx_q   <= (34'(now_x_rd_q) + $signed({3'b000, rad_rd_q}))
					- (34'(ax_q) + $signed({3'b000, ra_q}));
				dy_q   <= (34'(now_y_rd_q) + $signed({3'b000, rad_rd_q}))
					- (34'(ay_q) + $signed({3'b000, ra_q}));
				msum_q <= 32'(ra_q) + 32'(rad_rd_q);
			end
			ST_C_SQ2: begin
				sq_q <= prod_q[63:0];
			end
			ST_C_ROOT: begin
				dist_q <= arsp.result;
			end
			ST_C_CMP: begin
				ov_q  <= (dist_q < msum_q);
				ovl_q <= msum_q - dist_q;
			end
			ST_C_WX: begin
				qx_q <= arsp.result;
			end
			ST_C_WY: begin
				qy_q <= arsp.result;
			end
			ST_C_UPD: begin
				ax_q <= sat32(66'(ax_q) - 66'(cx));
				ay_q <= sat32(66'(ay_q) - 66'(cy));
				bx_q <= sat32(66'(bx_q) + 66'(cx));
				by_q <= sat32(66'(by_q) + 66'(cy));
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_which_q <= ld_which;
			out_x_q     <= ld_x;
			out_y_q     <= ld_y;
			out_ov_q    <= ld_ov;
			out_last_q  <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.which      = out_which_q;
	assign res.out_x      = out_x_q;
	assign res.out_y      = out_y_q;
	assign res.overlapped = out_ov_q;
	assign res.last       = out_last_q;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || res.ready))
		else $error("result register overwritten before it was taken");

endmodule
